/* hdl/bsc_pkg.sv */
// ----------------------------------------------------------------------------
// bsc_pkg: shared types and constants for the sensor compensation block
// Coefficient bundle, queue entry, sequencer states and register indexes.
// ----------------------------------------------------------------------------
package bsc_pkg;

    // Configuration register indexes
    localparam logic [1:0] REG_TEMP_COEFFS = 2'd0;
    localparam logic [1:0] REG_PRESS_LOW   = 2'd1;
    localparam logic [1:0] REG_PRESS_HIGH  = 2'd2;
    localparam logic [1:0] REG_PRESS_NINE  = 2'd3;

    // Front pipeline depth, divider length and pressure saturation value
    localparam int FRONT_STAGES = 10;
    localparam int DIV_STEPS    = 32;
    localparam logic [4:0]  DIV_LAST  = 5'(DIV_STEPS - 1);
    localparam logic [31:0] PRESS_SAT = 32'hFFFF_FFFF;

    // Unpacked calibration coefficients
    typedef struct packed {
        logic [15:0] t1;
        logic [15:0] t2;
        logic [15:0] t3;
        logic [15:0] p1;
        logic [15:0] p2;
        logic [15:0] p3;
        logic [15:0] p4;
        logic [15:0] p5;
        logic [15:0] p6;
        logic [15:0] p7;
        logic [15:0] p8;
        logic [15:0] p9;
    } bsc_coef_t;

    // One classified item handed from the front to the back
    typedef struct packed {
        logic [19:0] centi;   // finished temperature
        logic        neg;     // sign of the pressure quotient
        logic        dz;      // divisor is zero
        logic [79:0] num;     // |M| * 6250, low 32 zero bits implied
        logic [79:0] den;     // |B| * p1
    } bsc_job_t;

    // Back-end sequencer
    typedef enum logic [2:0] {
        S_IDLE,
        S_DIV,
        S_SQR,
        S_MUL,
        S_SUM,
        S_FIN
    } bsc_state_t;

endpackage

/* hdl/barometric_sensor_compensation.sv */
// ----------------------------------------------------------------------------
// barometric_sensor_compensation: raw temperature / pressure compensation
// Configuration registers, front pipeline, job queue and back-end divider.
// ----------------------------------------------------------------------------
// Raise start with a raw pair while busy is low; each accepted pair gives one
// result, shown for a single cycle with done high, in order of acceptance.
// The front pipeline is ten stages deep and takes a pair every cycle until
// QUEUE_DEPTH pairs are in flight; busy then holds until the back end takes
// one. The back end works on one pair at a time: a load, then the radix-2
// restoring divider over 32 quotient bits, then the square, multiply, sum and
// finish steps; the divider is skipped when the divisor is zero or the
// quotient saturates. Pairs accepted meanwhile wait in the queue. Results
// cannot be held off. Write coefficients only while no pair is in flight.
module barometric_sensor_compensation
    import bsc_pkg::*;
#(
    parameter int QUEUE_DEPTH = 4
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_write,
    input  logic [1:0]         cfg_index,
    input  logic [63:0]        cfg_data,
    input  logic               start,
    output logic               busy,
    input  logic [19:0]        raw_temperature,
    input  logic [19:0]        raw_pressure,
    output logic               done,
    output logic signed [19:0] temperature_centi,
    output logic [31:0]        pressure_q24_8,
    output logic               divide_by_zero
);

    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    logic [47:0]      temp_coeffs_reg;
    logic [63:0]      press_low_reg, press_high_reg;
    logic [15:0]      press_nine_reg;
    logic [CNT_W-1:0] inflight_reg;

    bsc_coef_t coef;
    bsc_job_t  front_job, head_job;
    logic      take, front_valid, head_present, pop;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            temp_coeffs_reg <= '0;
            press_low_reg   <= '0;
            press_high_reg  <= '0;
            press_nine_reg  <= '0;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                REG_TEMP_COEFFS: temp_coeffs_reg <= cfg_data[47:0];
                REG_PRESS_LOW:   press_low_reg   <= cfg_data;
                REG_PRESS_HIGH:  press_high_reg  <= cfg_data;
                REG_PRESS_NINE:  press_nine_reg  <= cfg_data[15:0];
                default: ;
            endcase
        end
    end

    // Unpack coefficients
    always_comb
    begin
        coef.t1 = temp_coeffs_reg[15:0];
        coef.t2 = temp_coeffs_reg[31:16];
        coef.t3 = temp_coeffs_reg[47:32];
        coef.p1 = press_low_reg[15:0];
        coef.p2 = press_low_reg[31:16];
        coef.p3 = press_low_reg[47:32];
        coef.p4 = press_low_reg[63:48];
        coef.p5 = press_high_reg[15:0];
        coef.p6 = press_high_reg[31:16];
        coef.p7 = press_high_reg[47:32];
        coef.p8 = press_high_reg[63:48];
        coef.p9 = press_nine_reg;
    end

    // Track pairs in the front pipeline and the queue
    assign busy = (inflight_reg >= CNT_W'(QUEUE_DEPTH));
    assign take = start && !busy;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            inflight_reg <= '0;
        end
        else if (take && !pop)
        begin
            inflight_reg <= inflight_reg + 1'b1;
        end
        else if (pop && !take)
        begin
            inflight_reg <= inflight_reg - 1'b1;
        end
    end

    bsc_front u_front (
        .clk             (clk),
        .rst_n           (rst_n),
        .take            (take),
        .raw_temperature (raw_temperature),
        .raw_pressure    (raw_pressure),
        .coef            (coef),
        .job_valid       (front_valid),
        .job             (front_job)
    );

    bsc_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (front_valid),
        .push_data (front_job),
        .pop       (pop),
        .present   (head_present),
        .head      (head_job)
    );

    bsc_back u_back (
        .clk               (clk),
        .rst_n             (rst_n),
        .job_present       (head_present),
        .job               (head_job),
        .coef              (coef),
        .pop               (pop),
        .temperature_centi (temperature_centi),
        .pressure_q24_8    (pressure_q24_8),
        .divide_by_zero    (divide_by_zero),
        .done              (done)
    );

    a_credit: assert property (@(posedge clk) disable iff (!rst_n)
        inflight_reg <= CNT_W'(QUEUE_DEPTH))
        else $error("in-flight count above queue depth");

endmodule

/* hdl/bsc_front.sv */
// ----------------------------------------------------------------------------
// bsc_front: temperature and divisor pipeline
// Ten-stage pipeline: temperature polynomial, t_fine, pressure numerator
// and divisor, reduced to magnitudes for the back-end divider.
// ----------------------------------------------------------------------------
module bsc_front
    import bsc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        take,
    input  logic [19:0] raw_temperature,
    input  logic [19:0] raw_pressure,
    input  bsc_coef_t   coef,
    output logic        job_valid,
    output bsc_job_t    job
);

    logic [FRONT_STAGES-1:0] vld_reg;

    logic signed [20:0] d1_reg;
    logic [19:0]        pr1_reg, pr2_reg, pr3_reg, pr4_reg, pr5_reg, pr6_reg, pr7_reg;
    logic signed [36:0] dt2_2_reg, dt2_3_reg;
    logic signed [41:0] dd2_reg;
    logic signed [57:0] ddt3_3_reg;
    logic signed [58:0] s4_reg;
    logic signed [23:0] a5_reg;
    logic [19:0]        centi5_reg, centi6_reg, centi7_reg, centi8_reg, centi9_reg;
    logic signed [47:0] aa6_reg;
    logic signed [39:0] ap5_6_reg, ap2_6_reg, ap5_7_reg, ap2_7_reg;
    logic signed [63:0] aap6_7_reg, aap3_7_reg;
    logic signed [63:0] m8_reg, b8_reg;
    logic [63:0]        mm9_reg, bm9_reg;
    logic               neg9_reg, dz9_reg;
    bsc_job_t           job_reg;

    logic signed [21:0] d_full;
    logic signed [36:0] dt2_c;
    logic signed [41:0] dd_c;
    logic signed [57:0] ddt3_c;
    logic signed [58:0] s_c;
    logic signed [58:0] s_bias;
    logic signed [61:0] s5x;
    logic signed [61:0] s5_bias;
    logic signed [23:0] a_c;
    logic signed [47:0] aa_c;
    logic signed [39:0] ap5_c, ap2_c;
    logic signed [63:0] aap6_c, aap3_c;
    logic signed [63:0] mbase, m_c, b_c;
    logic [63:0]        mm_c, bm_c;
    logic [79:0]        num_c, den_c;

    // Temperature polynomial
    always_comb
    begin
        d_full = $signed({2'b00, raw_temperature}) - $signed({2'b00, coef.t1, 4'h0});
        dt2_c  = d1_reg * $signed(coef.t2);
        dd_c   = d1_reg * d1_reg;
        ddt3_c = dd2_reg * $signed(coef.t3);
        s_c    = 59'($signed({dt2_3_reg, 20'h0})) + 59'(ddt3_3_reg);
    end

    // Truncate toward zero: t_fine and centidegrees (quotient always fits 20 bits)
    always_comb
    begin
        s_bias  = s4_reg + (s4_reg[58] ? $signed({25'd0, {34{1'b1}}}) : 59'sd0);
        a_c     = 24'($signed(s_bias[58:34]) - 25'sd128000);
        s5x     = (62'(s4_reg) <<< 2) + 62'(s4_reg);
        s5_bias = s5x + (s5x[61] ? $signed({20'd0, {42{1'b1}}}) : 62'sd0);
    end

    // Pressure polynomial terms
    always_comb
    begin
        aa_c   = a5_reg * a5_reg;
        ap5_c  = a5_reg * $signed(coef.p5);
        ap2_c  = a5_reg * $signed(coef.p2);
        aap6_c = aa6_reg * $signed(coef.p6);
        aap3_c = aa6_reg * $signed(coef.p3);
        mbase  = $signed({12'd0, 21'(21'h100000 - {1'b0, pr7_reg}), 31'd0});
        m_c    = mbase - aap6_7_reg - (64'(ap5_7_reg) <<< 17)
                 - (64'($signed(coef.p4)) <<< 35);
        b_c    = $signed(64'h0080_0000_0000_0000) + aap3_7_reg + (64'(ap2_7_reg) <<< 20);
    end

    // Magnitudes and scaled numerator / divisor
    always_comb
    begin
        mm_c  = m8_reg[63] ? (64'd0 - m8_reg) : m8_reg;
        bm_c  = b8_reg[63] ? (64'd0 - b8_reg) : b8_reg;
        num_c = mm9_reg * 14'd6250;
        den_c = bm9_reg * coef.p1;
    end

    // Advance the valid flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= {vld_reg[FRONT_STAGES-2:0], take};
        end
    end

    // Pipeline payload
    always_ff @(posedge clk)
    begin
        d1_reg     <= d_full[20:0];
        pr1_reg    <= raw_pressure;

        dt2_2_reg  <= dt2_c;
        dd2_reg    <= dd_c;
        pr2_reg    <= pr1_reg;

        dt2_3_reg  <= dt2_2_reg;
        ddt3_3_reg <= ddt3_c;
        pr3_reg    <= pr2_reg;

        s4_reg     <= s_c;
        pr4_reg    <= pr3_reg;

        a5_reg     <= a_c;
        centi5_reg <= s5_bias[61:42];
        pr5_reg    <= pr4_reg;

        aa6_reg    <= aa_c;
        ap5_6_reg  <= ap5_c;
        ap2_6_reg  <= ap2_c;
        centi6_reg <= centi5_reg;
        pr6_reg    <= pr5_reg;

        aap6_7_reg <= aap6_c;
        aap3_7_reg <= aap3_c;
        ap5_7_reg  <= ap5_6_reg;
        ap2_7_reg  <= ap2_6_reg;
        centi7_reg <= centi6_reg;
        pr7_reg    <= pr6_reg;

        m8_reg     <= m_c;
        b8_reg     <= b_c;
        centi8_reg <= centi7_reg;

        mm9_reg    <= mm_c;
        bm9_reg    <= bm_c;
        neg9_reg   <= m8_reg[63] ^ b8_reg[63];
        dz9_reg    <= (b8_reg == 64'sd0) || (coef.p1 == 16'd0);
        centi9_reg <= centi8_reg;

        job_reg.centi <= centi9_reg;
        job_reg.neg   <= neg9_reg;
        job_reg.dz    <= dz9_reg;
        job_reg.num   <= num_c;
        job_reg.den   <= den_c;
    end

    assign job_valid = vld_reg[FRONT_STAGES-1];
    assign job       = job_reg;

endmodule

/* hdl/bsc_queue.sv */
// ----------------------------------------------------------------------------
// bsc_queue: job queue between front and back
// Small circular buffer; the top level's credit count keeps it from overflow.
// ----------------------------------------------------------------------------
module bsc_queue
    import bsc_pkg::*;
#(
    parameter int DEPTH = 4
)
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     push,
    input  bsc_job_t push_data,
    input  logic     pop,
    output logic     present,
    output bsc_job_t head
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    bsc_job_t           mem [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0]   count_reg;

    // Store incoming jobs
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

    // Advance pointers and occupancy
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    assign present = (count_reg != '0);
    assign head    = mem[rd_ptr_reg];

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(push && !pop && count_reg == CNT_W'(DEPTH)))
        else $error("job queue overflow");

endmodule

/* hdl/bsc_back.sv */
// ----------------------------------------------------------------------------
// bsc_back: pressure divider and second-order correction
// Radix-2 restoring divider over 32 quotient bits, then correction terms,
// clamp and a result transfer marked by a one-cycle done strobe.
// ----------------------------------------------------------------------------
module bsc_back
    import bsc_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               job_present,
    input  bsc_job_t           job,
    input  bsc_coef_t          coef,
    output logic               pop,
    output logic signed [19:0] temperature_centi,
    output logic [31:0]        pressure_q24_8,
    output logic               divide_by_zero,
    output logic               done
);

    bsc_state_t state_reg, state_next;

    logic [4:0]         cnt_reg;
    logic [79:0]        rem_reg, den_reg;
    logic [31:0]        q_reg;
    logic               neg_reg, dz_reg;
    logic [19:0]        centi_reg;
    logic signed [33:0] ps_reg;
    logic [39:0]        sq_reg;
    logic signed [48:0] p8pm_reg;
    logic signed [49:0] p8ps_reg;
    logic signed [56:0] p9sq_reg;
    logic signed [42:0] sum_reg;

    logic               done_reg, dz_out_reg;
    logic [19:0]        temp_out_reg;
    logic [31:0]        press_out_reg;

    logic               skip_div, div_step, fin;
    logic [80:0]        r2;
    logic               ge;
    logic [63:0]        qq;
    logic signed [33:0] pm_s;
    logic signed [48:0] p8pm_c;
    logic signed [56:0] p9sq_c;
    logic signed [56:0] p9sq_bias;
    logic signed [49:0] p8ps_bias;
    logic signed [42:0] sum_c;
    logic signed [42:0] sum_bias;
    logic signed [43:0] fin_c;
    logic [31:0]        press_c;

    assign skip_div = job.dz || (job.num >= job.den);

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (job_present)
                begin
                    state_next = skip_div ? S_SQR : S_DIV;
                end
            end
            S_DIV:
            begin
                if (cnt_reg == DIV_LAST)
                begin
                    state_next = S_SQR;
                end
            end
            S_SQR:   state_next = S_MUL;
            S_MUL:   state_next = S_SUM;
            S_SUM:   state_next = S_FIN;
            S_FIN:   state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    // Sequencer outputs
    always_comb
    begin
        pop      = 1'b0;
        div_step = 1'b0;
        fin      = 1'b0;
        case (state_reg)
            S_IDLE:  pop      = job_present;
            S_DIV:   div_step = 1'b1;
            S_FIN:   fin      = 1'b1;
            default: ;
        endcase
    end

    // Divider step and correction arithmetic
    always_comb
    begin
        r2        = {rem_reg, 1'b0};
        ge        = (r2 >= {1'b0, den_reg});
        qq        = q_reg * q_reg;
        pm_s      = $signed({2'b00, q_reg});
        p8pm_c    = $signed(coef.p8) * $signed({1'b0, q_reg});
        p9sq_c    = $signed(coef.p9) * $signed({1'b0, sq_reg});
        p9sq_bias = p9sq_reg + (p9sq_reg[56] ? 57'sd32767 : 57'sd0);
        p8ps_bias = p8ps_reg + (p8ps_reg[49] ? 50'sd32767 : 50'sd0);
        sum_c     = 43'($signed(p9sq_bias[56:15])) + 43'($signed(p8ps_bias[49:15]))
                    + 43'($signed({coef.p7, 8'h00}));
        sum_bias  = sum_reg + (sum_reg[42] ? 43'sd15 : 43'sd0);
        fin_c     = 44'(ps_reg) + 44'($signed(sum_bias[42:4]));
        if (fin_c[43])
        begin
            press_c = 32'd0;
        end
        else if (fin_c[42:32] != 11'd0)
        begin
            press_c = PRESS_SAT;
        end
        else
        begin
            press_c = fin_c[31:0];
        end
    end

    // State and result strobe
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= fin;
        end
    end

    // Datapath
    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            rem_reg   <= job.num;
            den_reg   <= job.den;
            neg_reg   <= job.neg;
            dz_reg    <= job.dz;
            centi_reg <= job.centi;
            cnt_reg   <= '0;
            q_reg     <= job.dz ? 32'd0 : (skip_div ? PRESS_SAT : 32'd0);
        end
        if (div_step)
        begin
            rem_reg <= ge ? 80'(r2 - {1'b0, den_reg}) : r2[79:0];
            q_reg   <= {q_reg[30:0], ge};
            cnt_reg <= cnt_reg + 1'b1;
        end
        if (state_reg == S_SQR)
        begin
            ps_reg   <= neg_reg ? -pm_s : pm_s;
            sq_reg   <= qq[63:24];
            p8pm_reg <= p8pm_c;
        end
        if (state_reg == S_MUL)
        begin
            p9sq_reg <= p9sq_c;
            p8ps_reg <= neg_reg ? -50'(p8pm_reg) : 50'(p8pm_reg);
        end
        if (state_reg == S_SUM)
        begin
            sum_reg <= sum_c;
        end
        if (fin)
        begin
            temp_out_reg  <= centi_reg;
            press_out_reg <= dz_reg ? 32'd0 : press_c;
            dz_out_reg    <= dz_reg;
        end
    end

    assign done              = done_reg;
    assign temperature_centi = $signed(temp_out_reg);
    assign pressure_q24_8    = press_out_reg;
    assign divide_by_zero    = dz_out_reg;

    a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DIV) |-> (rem_reg < den_reg))
        else $error("divider remainder out of range");

    a_dz_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && divide_by_zero) |-> (pressure_q24_8 == 32'd0))
        else $error("zero divisor gave nonzero pressure");

endmodule
